// ----- src/bbsn_pkg.sv -----
// bbsn_pkg: widths, register indexes and pipeline types for the bevelled box normal block
// no dependencies; used by bevel_box_surface_normal
`timescale 1ns / 1ps
`default_nettype none

package bbsn_pkg;

  // coordinate and normal formats
  localparam int CW   = 21;        // signed coordinate width
  localparam int NF   = 14;        // normal / rotation fraction bits
  localparam int RW   = NF + 2;    // rotation entry and normal width
  localparam int ONE  = 1 << NF;   // 1.0 in normal units
  localparam int RADW = CW - 1;    // unsigned radius width
  localparam int ROWW = 3 * RW;    // packed rotation row
  localparam int CRNW = 3 * CW;    // packed coordinate triple

  // configuration port
  localparam int CFG_DW = CRNW;
  localparam int CFG_IW = 3;

  // box frame transform
  localparam int DW   = CW + 1;    // p - t
  localparam int PW   = RW + DW;   // one rotation product
  localparam int AW   = PW + 2;    // sum of three products
  localparam int RELW = AW - NF;   // local coordinate
  localparam int LIMW = CW + 2;    // corner -/+ radius
  localparam int DLW  = RELW + 1;  // distance past a limit
  localparam int MAGW = DLW - 1;   // local normal magnitude

  // length
  localparam int SQW  = 2 * MAGW;
  localparam int SUMW = SQW + 2;
  localparam int NRMW = 62;        // normalised squared length field
  localparam int SQ_STEPS = NRMW / 2;
  localparam int SHW  = 5;
  localparam int LENW = SQ_STEPS;  // root width

  // divide
  localparam int DVW  = LENW + 1;           // divisor 2*len
  localparam int QW   = NF + 1;             // quotient up to 1.0
  localparam int NUMW = DVW + NF + 1;       // 2*num + len
  localparam int WIDEW = MAGW + DVW;        // magnitude before truncation

  // world rotation
  localparam int NPW  = 2 * RW;
  localparam int NACW = NPW + 2;
  localparam int WSW  = NACW - NF;

  typedef enum logic [CFG_IW-1:0] {
    CFG_ROT_ROW_0    = 3'd0,
    CFG_ROT_ROW_1    = 3'd1,
    CFG_ROT_ROW_2    = 3'd2,
    CFG_TRANSLATION  = 3'd3,
    CFG_MIN_CORNER   = 3'd4,
    CFG_MAX_CORNER   = 3'd5,
    CFG_BEVEL_RADIUS = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic       vld;
    logic       has_n;
    logic       degen;
    logic [2:0] neg;
  } ctl_t;

  typedef struct packed {
    ctl_t                     ctl;
    logic [2:0][MAGW-1:0]     mag;
    logic [SHW-1:0]           sh;
  } sqc_t;

  typedef struct packed {
    logic                 has_n;
    logic                 degen;
    logic signed [RW-1:0] nx;
    logic signed [RW-1:0] ny;
    logic signed [RW-1:0] nz;
  } res_t;

endpackage

`default_nettype wire

// ----- src/bevel_box_surface_normal.sv -----
// bevel_box_surface_normal: outward normal of a box with rounded edges, fully pipelined
// depends on bbsn_pkg (widths, register indexes, pipeline structs)
// throughput: one request per cycle while in_stall is low (output buffer not full);
//   the integer square root (31 stages) and the restoring divider (15 stages) set
//   the depth, a two-entry output buffer the stall point
// reset: synchronous active-low rst_n clears every stage valid and the output buffer,
//   and sets the rotation to identity and translation, corners and radius to zero
`timescale 1ns / 1ps
`default_nettype none

module bevel_box_surface_normal (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [bbsn_pkg::CFG_IW-1:0]       cfg_index,
  input  wire logic [bbsn_pkg::CFG_DW-1:0]       cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic signed [bbsn_pkg::CW-1:0]    in_pos_x,
  input  wire logic signed [bbsn_pkg::CW-1:0]    in_pos_y,
  input  wire logic signed [bbsn_pkg::CW-1:0]    in_pos_z,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic                                   out_has_normal,
  output logic                                   out_degenerate,
  output logic signed [bbsn_pkg::RW-1:0]         out_normal_x,
  output logic signed [bbsn_pkg::RW-1:0]         out_normal_y,
  output logic signed [bbsn_pkg::RW-1:0]         out_normal_z
);

  localparam int CW   = bbsn_pkg::CW;
  localparam int NF   = bbsn_pkg::NF;
  localparam int RW   = bbsn_pkg::RW;
  localparam int ONE  = bbsn_pkg::ONE;
  localparam int RADW = bbsn_pkg::RADW;
  localparam int ROWW = bbsn_pkg::ROWW;
  localparam int CRNW = bbsn_pkg::CRNW;
  localparam int DW   = bbsn_pkg::DW;
  localparam int PW   = bbsn_pkg::PW;
  localparam int AW   = bbsn_pkg::AW;
  localparam int RELW = bbsn_pkg::RELW;
  localparam int LIMW = bbsn_pkg::LIMW;
  localparam int DLW  = bbsn_pkg::DLW;
  localparam int MAGW = bbsn_pkg::MAGW;
  localparam int SQW  = bbsn_pkg::SQW;
  localparam int SUMW = bbsn_pkg::SUMW;
  localparam int NRMW = bbsn_pkg::NRMW;
  localparam int SQ_STEPS = bbsn_pkg::SQ_STEPS;
  localparam int SHW  = bbsn_pkg::SHW;
  localparam int LENW = bbsn_pkg::LENW;
  localparam int DVW  = bbsn_pkg::DVW;
  localparam int QW   = bbsn_pkg::QW;
  localparam int NUMW = bbsn_pkg::NUMW;
  localparam int WIDEW = bbsn_pkg::WIDEW;
  localparam int NPW  = bbsn_pkg::NPW;
  localparam int NACW = bbsn_pkg::NACW;
  localparam int WSW  = bbsn_pkg::WSW;

  // ---------------------------------------------------------------------------
  // configuration registers, written only while the pipe is empty: a rule for the user, not enforced here
  // ---------------------------------------------------------------------------
  logic [ROWW-1:0] rot_r [3];
  logic [CRNW-1:0] trans_r, min_r, max_r;
  logic [RADW-1:0] rad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_r[0] <= ROWW'(ONE);
      rot_r[1] <= ROWW'(ONE) << RW;
      rot_r[2] <= ROWW'(ONE) << (2 * RW);
      trans_r  <= '0;
      min_r    <= '0;
      max_r    <= '0;
      rad_r    <= '0;
    end else if (cfg_we) begin
      unique case (bbsn_pkg::cfg_idx_t'(cfg_index))
        bbsn_pkg::CFG_ROT_ROW_0:    rot_r[0] <= cfg_data[ROWW-1:0];
        bbsn_pkg::CFG_ROT_ROW_1:    rot_r[1] <= cfg_data[ROWW-1:0];
        bbsn_pkg::CFG_ROT_ROW_2:    rot_r[2] <= cfg_data[ROWW-1:0];
        bbsn_pkg::CFG_TRANSLATION:  trans_r  <= cfg_data[CRNW-1:0];
        bbsn_pkg::CFG_MIN_CORNER:   min_r    <= cfg_data[CRNW-1:0];
        bbsn_pkg::CFG_MAX_CORNER:   max_r    <= cfg_data[CRNW-1:0];
        bbsn_pkg::CFG_BEVEL_RADIUS: rad_r    <= cfg_data[RADW-1:0];
        default: ;
      endcase
    end
  end

  // unpacked views of the packed registers
  logic signed [RW-1:0] rm [3][3];     // rm[row][col]
  logic signed [CW-1:0] trn [3];
  logic signed [CW-1:0] bmin [3];
  logic signed [CW-1:0] bmax [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        rm[i][j] = rot_r[i][j*RW +: RW];
      end
      trn[i]  = trans_r[i*CW +: CW];
      bmin[i] = min_r[i*CW +: CW];
      bmax[i] = max_r[i*CW +: CW];
    end
  end

  // ---------------------------------------------------------------------------
  // flow control: the whole pipe advances together unless the output buffer
  // is full, so in_stall never looks at out_stall directly
  // ---------------------------------------------------------------------------
  logic [1:0] cnt_r;
  logic       adv;

  assign adv      = (cnt_r != 2'd2);
  assign in_stall = ~adv;

  // ---------------------------------------------------------------------------
  // stage 1: p - t
  // ---------------------------------------------------------------------------
  logic signed [CW-1:0] pos [3];
  logic signed [DW-1:0] d1_nxt [3];
  logic signed [DW-1:0] d1_r [3];
  logic                 v1_r;

  assign pos[0] = in_pos_x;
  assign pos[1] = in_pos_y;
  assign pos[2] = in_pos_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d1_nxt[i] = DW'(pos[i]) - DW'(trn[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
    end
    if (adv) begin
      d1_r <= d1_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: nine products of R^T (p - t)
  // ---------------------------------------------------------------------------
  logic signed [PW-1:0] p2_nxt [3][3];   // [row j][axis i]
  logic signed [PW-1:0] p2_r [3][3];
  logic                 v2_r;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      for (int i = 0; i < 3; i++) begin
        p2_nxt[j][i] = PW'(rm[j][i]) * PW'(d1_r[j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
    if (adv) begin
      p2_r <= p2_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 3: sum, round half up, floor to coordinate units
  // ---------------------------------------------------------------------------
  localparam logic signed [AW-1:0] REL_RND = AW'(1) << (NF - 1);

  logic signed [AW-1:0]   acc3 [3];
  logic signed [RELW-1:0] rel3_nxt [3];
  logic signed [RELW-1:0] rel3_r [3];
  logic                   v3_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc3[i] = AW'(p2_r[0][i]) + AW'(p2_r[1][i]) + AW'(p2_r[2][i]) + REL_RND;
      rel3_nxt[i] = acc3[i][AW-1:NF];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= v2_r;
    end
    if (adv) begin
      rel3_r <= rel3_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 4: region test per axis and local normal magnitude
  // ---------------------------------------------------------------------------
  logic signed [LIMW-1:0] lmax [3];
  logic signed [LIMW-1:0] lmin [3];
  logic signed [DLW-1:0]  dmax [3];
  logic signed [DLW-1:0]  dmin [3];
  logic signed [DLW-1:0]  ndmin [3];
  logic signed [DLW-1:0]  big [3];
  logic [2:0]             ge, le, nz, sneg;
  logic [MAGW-1:0]        mag4_nxt [3];
  bbsn_pkg::ctl_t         c4_nxt, c4_r;
  logic [MAGW-1:0]        mag4_r [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lmax[i]  = LIMW'(bmax[i]) - LIMW'($signed({1'b0, rad_r}));
      lmin[i]  = LIMW'(bmin[i]) + LIMW'($signed({1'b0, rad_r}));
      dmax[i]  = DLW'(rel3_r[i]) - DLW'(lmax[i]);
      dmin[i]  = DLW'(rel3_r[i]) - DLW'(lmin[i]);
      ndmin[i] = -dmin[i];
      ge[i]    = ~dmax[i][DLW-1];
      le[i]    = dmin[i][DLW-1] | (dmin[i] == '0);
      sneg[i]  = le[i] & ~ge[i];
      nz[i]    = ge[i] ^ le[i];
      big[i]   = (dmax[i] > ndmin[i]) ? dmax[i] : ndmin[i];
      mag4_nxt[i] = nz[i] ? big[i][MAGW-1:0] : '0;
    end
    c4_nxt.vld   = v3_r;
    // edge or corner: at least two axes outside the flat band
    c4_nxt.has_n = (nz[0] & nz[1]) | (nz[0] & nz[2]) | (nz[1] & nz[2]);
    c4_nxt.degen = 1'b0;
    c4_nxt.neg   = sneg;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c4_r <= '0;
    end else if (adv) begin
      c4_r <= c4_nxt;
    end
    if (adv) begin
      mag4_r <= mag4_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 5: squares
  // ---------------------------------------------------------------------------
  logic [SQW-1:0]  sq5_nxt [3];
  logic [SQW-1:0]  sq5_r [3];
  logic [MAGW-1:0] mag5_r [3];
  bbsn_pkg::ctl_t  c5_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq5_nxt[i] = SQW'(mag4_r[i]) * SQW'(mag4_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c5_r <= '0;
    end else if (adv) begin
      c5_r <= c4_r;
    end
    if (adv) begin
      sq5_r  <= sq5_nxt;
      mag5_r <= mag4_r;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 6: squared length and the zero-length case
  // ---------------------------------------------------------------------------
  logic [SUMW-1:0] s6_nxt, s6_r;
  logic [MAGW-1:0] mag6_r [3];
  bbsn_pkg::ctl_t  c6_nxt, c6_r;

  always_comb begin
    s6_nxt = SUMW'(sq5_r[0]) + SUMW'(sq5_r[1]) + SUMW'(sq5_r[2]);
    c6_nxt = c5_r;
    c6_nxt.degen = c5_r.has_n & (s6_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c6_r <= '0;
    end else if (adv) begin
      c6_r <= c6_nxt;
    end
    if (adv) begin
      s6_r   <= s6_nxt;
      mag6_r <= mag5_r;
    end
  end

  // ---------------------------------------------------------------------------
  // stages 7 and 8: scale the squared length up by powers of four until its
  // top pair of bits is nonzero; sh counts the factors of two on the root
  // ---------------------------------------------------------------------------
  logic [NRMW-1:0] n7_nxt, n7_r;
  logic [SHW-1:0]  sh7_nxt, sh7_r;
  logic [MAGW-1:0] mag7_r [3];
  bbsn_pkg::ctl_t  c7_r;

  always_comb begin
    n7_nxt  = NRMW'(s6_r);
    sh7_nxt = '0;
    if (n7_nxt[NRMW-1 -: 32] == '0) begin
      n7_nxt  = n7_nxt << 32;
      sh7_nxt = sh7_nxt + SHW'(16);
    end
    if (n7_nxt[NRMW-1 -: 16] == '0) begin
      n7_nxt  = n7_nxt << 16;
      sh7_nxt = sh7_nxt + SHW'(8);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c7_r <= '0;
    end else if (adv) begin
      c7_r <= c6_r;
    end
    if (adv) begin
      n7_r   <= n7_nxt;
      sh7_r  <= sh7_nxt;
      mag7_r <= mag6_r;
    end
  end

  logic [NRMW-1:0]  n8_nxt;
  logic [SHW-1:0]   sh8_nxt;
  bbsn_pkg::sqc_t   sq0_nxt;

  // square root pipeline registers; index 0 is the stage 8 output
  logic [NRMW-1:0]  sx_r [SQ_STEPS+1];
  logic [NRMW-1:0]  sr_r [1:SQ_STEPS];
  bbsn_pkg::sqc_t   sc_r [SQ_STEPS+1];

  always_comb begin
    n8_nxt  = n7_r;
    sh8_nxt = sh7_r;
    if (n8_nxt[NRMW-1 -: 8] == '0) begin
      n8_nxt  = n8_nxt << 8;
      sh8_nxt = sh8_nxt + SHW'(4);
    end
    if (n8_nxt[NRMW-1 -: 4] == '0) begin
      n8_nxt  = n8_nxt << 4;
      sh8_nxt = sh8_nxt + SHW'(2);
    end
    if (n8_nxt[NRMW-1 -: 2] == '0) begin
      n8_nxt  = n8_nxt << 2;
      sh8_nxt = sh8_nxt + SHW'(1);
    end
    sq0_nxt.ctl = c7_r;
    for (int i = 0; i < 3; i++) begin
      sq0_nxt.mag[i] = mag7_r[i];
    end
    sq0_nxt.sh = sh8_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_r[0].ctl <= '0;
    end else if (adv) begin
      sc_r[0] <= sq0_nxt;
    end
    if (adv) begin
      sx_r[0] <= n8_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // stages 9 to 39: integer square root, one result bit per stage
  // ---------------------------------------------------------------------------
  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    localparam logic [NRMW:0] BIT = (NRMW + 1)'(1) << (NRMW - 2 - 2 * k);

    logic [NRMW-1:0] rin;
    logic [NRMW:0]   trial;
    logic            take;
    logic [NRMW-1:0] x_nxt, r_nxt;

    if (k == 0) begin : g_first
      assign rin = '0;
    end else begin : g_rest
      assign rin = sr_r[k];
    end

    always_comb begin
      trial = {1'b0, rin} + BIT;
      take  = ({1'b0, sx_r[k]} >= trial);
      x_nxt = take ? (sx_r[k] - trial[NRMW-1:0]) : sx_r[k];
      r_nxt = take ? ((rin >> 1) + BIT[NRMW-1:0]) : (rin >> 1);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sc_r[k+1].ctl <= '0;
      end else if (adv) begin
        sc_r[k+1] <= sc_r[k];
      end
      if (adv) begin
        sx_r[k+1] <= x_nxt;
        sr_r[k+1] <= r_nxt;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stage 40: scaled numerators 2*(mag << sh << NF) + len and divisor 2*len
  // ---------------------------------------------------------------------------
  logic [LENW-1:0]  len40;
  logic [WIDEW-1:0] wide40 [3];
  logic [NUMW-1:0]  rem40_nxt [3];
  logic [DVW-1:0]   d40_nxt;

  logic [NUMW-1:0]  dr_r [QW][3];
  logic [DVW-1:0]   dd_r [QW];
  logic [QW-1:0]    dq_r [1:QW][3];
  bbsn_pkg::ctl_t   dc_r [QW+1];

  always_comb begin
    len40   = sr_r[SQ_STEPS][LENW-1:0];
    d40_nxt = {len40, 1'b0};
    for (int i = 0; i < 3; i++) begin
      wide40[i]    = WIDEW'(sc_r[SQ_STEPS].mag[i]) << sc_r[SQ_STEPS].sh;
      rem40_nxt[i] = {wide40[i][DVW-1:0], {(NF+1){1'b0}}} + NUMW'(len40);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dc_r[0] <= '0;
    end else if (adv) begin
      dc_r[0] <= sc_r[SQ_STEPS].ctl;
    end
    if (adv) begin
      dr_r[0] <= rem40_nxt;
      dd_r[0] <= d40_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // stages 41 to 55: restoring divide, one quotient bit per stage, three lanes
  // ---------------------------------------------------------------------------
  for (genvar t = 0; t < QW; t++) begin : g_div
    localparam int K = QW - 1 - t;

    logic [NUMW-1:0] trial;
    logic [QW-1:0]   qin [3];
    logic [NUMW-1:0] rem_nxt [3];
    logic [QW-1:0]   q_nxt [3];

    for (genvar i = 0; i < 3; i++) begin : g_lane
      if (t == 0) begin : g_first
        assign qin[i] = '0;
      end else begin : g_rest
        assign qin[i] = dq_r[t][i];
      end
    end

    always_comb begin
      trial = NUMW'(dd_r[t]) << K;
      for (int i = 0; i < 3; i++) begin
        if (dr_r[t][i] >= trial) begin
          rem_nxt[i] = dr_r[t][i] - trial;
          q_nxt[i]   = qin[i] | (QW'(1) << K);
        end else begin
          rem_nxt[i] = dr_r[t][i];
          q_nxt[i]   = qin[i];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dc_r[t+1] <= '0;
      end else if (adv) begin
        dc_r[t+1] <= dc_r[t];
      end
      if (adv) begin
        dq_r[t+1] <= q_nxt;
      end
    end

    if (t < QW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (adv) begin
          dr_r[t+1] <= rem_nxt;
          dd_r[t+1] <= dd_r[t];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stage 56: cap at 1.0, apply sign, rotate back by R
  // ---------------------------------------------------------------------------
  logic [QW-1:0]         qc [3];
  logic signed [RW-1:0]  nl [3];
  logic signed [NPW-1:0] pm_nxt [3][3];
  logic signed [NPW-1:0] pm_r [3][3];
  bbsn_pkg::ctl_t        pc_r;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      qc[j] = (dq_r[QW][j] > QW'(ONE)) ? QW'(ONE) : dq_r[QW][j];
      nl[j] = dc_r[QW].neg[j] ? -$signed(RW'(qc[j])) : $signed(RW'(qc[j]));
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        pm_nxt[i][j] = NPW'(rm[i][j]) * NPW'(nl[j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= '0;
    end else if (adv) begin
      pc_r <= dc_r[QW];
    end
    if (adv) begin
      pm_r <= pm_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // final sum, round half up, saturate to +/-1.0; written into the output buffer
  // ---------------------------------------------------------------------------
  localparam logic signed [NACW-1:0] W_RND = NACW'(1) << (NF - 1);
  localparam logic signed [WSW-1:0]  W_MAX = WSW'(ONE);
  localparam logic signed [WSW-1:0]  W_MIN = -WSW'(ONE);

  logic signed [NACW-1:0] wacc [3];
  logic signed [WSW-1:0]  wsh [3];
  logic signed [RW-1:0]   wsat [3];
  logic                   nrm_ok;
  bbsn_pkg::res_t         res_nxt;

  always_comb begin
    nrm_ok = pc_r.has_n & ~pc_r.degen;
    for (int i = 0; i < 3; i++) begin
      wacc[i] = NACW'(pm_r[i][0]) + NACW'(pm_r[i][1]) + NACW'(pm_r[i][2]) + W_RND;
      wsh[i]  = wacc[i][NACW-1:NF];
      if (!nrm_ok) begin
        wsat[i] = '0;
      end else if (wsh[i] > W_MAX) begin
        wsat[i] = RW'(ONE);
      end else if (wsh[i] < W_MIN) begin
        wsat[i] = -RW'(ONE);
      end else begin
        wsat[i] = wsh[i][RW-1:0];
      end
    end
    res_nxt.has_n = pc_r.has_n;
    res_nxt.degen = pc_r.degen;
    res_nxt.nx    = wsat[0];
    res_nxt.ny    = wsat[1];
    res_nxt.nz    = wsat[2];
  end

  // ---------------------------------------------------------------------------
  // two-entry output buffer: the pipe keeps moving while one result waits
  // ---------------------------------------------------------------------------
  bbsn_pkg::res_t ent_r [2];
  logic           wp_r, rp_r;
  logic           push, pop;
  bbsn_pkg::res_t head;

  assign push      = adv & pc_r.vld;
  assign out_valid = (cnt_r != 2'd0);
  assign pop       = out_valid & ~out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
    if (push) begin
      ent_r[wp_r] <= res_nxt;
    end
  end

  assign head           = ent_r[rp_r];
  assign out_has_normal = head.has_n;
  assign out_degenerate = head.degen;
  assign out_normal_x   = head.nx;
  assign out_normal_y   = head.ny;
  assign out_normal_z   = head.nz;

endmodule

`default_nettype wire
